FILE: rtl/triangle_overlap_2d_defines.svh
// Assertion macros shared by the triangle overlap RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef TRIANGLE_OVERLAP_2D_DEFINES_SVH
`define TRIANGLE_OVERLAP_2D_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define TOV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held
`define TOV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tov_pkg.sv
// Shared types and constants of the triangle overlap block.
// No dependencies; imported by every module of the block.
package tov_pkg;

  // Default coordinate width, signed Q8.8
  localparam int COORD_BITS_DEF = 16;

  // Tolerance register width, signed Q16.16
  localparam int EPS_BITS = 32;

  // Configuration register index width
  localparam int CFG_IDX_BITS = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_EDGE_EPSILON   = 2'd0,
    REG_ALLOW_REVERSED = 2'd1,
    REG_TOUCH_COLLIDES = 2'd2
  } tov_reg_t;

  // Reset values of the configuration registers
  localparam logic [EPS_BITS-1:0] EDGE_EPSILON_RST   = '0;
  localparam logic                ALLOW_REVERSED_RST = 1'b1;
  localparam logic                TOUCH_COLLIDES_RST = 1'b1;

  // Live configuration handed to the separation checks
  typedef struct packed {
    logic [EPS_BITS-1:0] edge_epsilon;
    logic                allow_reversed;
    logic                touch_collides;
  } tov_cfg_t;

endpackage

FILE: rtl/tov_det.sv
// Edge determinant of three points: cross product (q - p) x (r - p), exact.
// Depends on tov_pkg for the default coordinate width; no submodules.
module tov_det #(
  parameter int COORD_BITS = tov_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0]   px,
  input  logic signed [COORD_BITS-1:0]   py,
  input  logic signed [COORD_BITS-1:0]   qx,
  input  logic signed [COORD_BITS-1:0]   qy,
  input  logic signed [COORD_BITS-1:0]   rx,
  input  logic signed [COORD_BITS-1:0]   ry,
  output logic signed [2*COORD_BITS+2:0] det
);
  import tov_pkg::*;

  localparam int DIFW = COORD_BITS + 1;
  localparam int PW   = 2 * COORD_BITS + 2;
  localparam int DW   = 2 * COORD_BITS + 3;

  logic signed [DIFW-1:0] dqx, dqy, drx, dry;
  logic signed [PW-1:0]   prod_a, prod_b;

  // Form edge and point offsets relative to p
  assign dqx = DIFW'(qx) - DIFW'(px);
  assign dqy = DIFW'(qy) - DIFW'(py);
  assign drx = DIFW'(rx) - DIFW'(px);
  assign dry = DIFW'(ry) - DIFW'(py);

  // Cross product; both products fit in PW bits
  assign prod_a = PW'(dqx) * PW'(dry);
  assign prod_b = PW'(dqy) * PW'(drx);
  assign det    = DW'(prod_a) - DW'(prod_b);

endmodule

FILE: rtl/tov_sep.sv
// Separating-edge check: each edge of one triangle against every vertex of the other.
// Depends on tov_pkg for the configuration struct and tolerance width.
module tov_sep #(
  parameter int COORD_BITS = tov_pkg::COORD_BITS_DEF
) (
  input  logic signed [2*COORD_BITS+2:0] det_i [3][3],
  input  logic                           flip,
  input  tov_pkg::tov_cfg_t              cfg,
  output logic                           sep
);
  import tov_pkg::*;

  localparam int DW   = 2 * COORD_BITS + 3;
  localparam int CMPW = (DW + 1 > EPS_BITS) ? DW + 1 : EPS_BITS;

  logic signed [CMPW-1:0] eps_ext;
  logic signed [CMPW-1:0] val   [3][3];
  logic                   below [3][3];
  logic [2:0]             edge_sep;

  assign eps_ext = CMPW'($signed(cfg.edge_epsilon));

  // Reversed winding flips every edge, which negates its determinant
  for (genvar gi = 0; gi < 3; gi++) begin : g_edge
    for (genvar gk = 0; gk < 3; gk++) begin : g_vtx
      assign val[gi][gk]   = flip ? -CMPW'(det_i[gi][gk]) : CMPW'(det_i[gi][gk]);
      assign below[gi][gk] = cfg.touch_collides ? (val[gi][gk] < eps_ext)
                                                : (val[gi][gk] <= eps_ext);
    end
    // Edge separates when all three far vertices lie outside it
    assign edge_sep[gi] = below[gi][0] & below[gi][1] & below[gi][2];
  end

  assign sep = |edge_sep;

endmodule

FILE: rtl/triangle_overlap_2d.sv
// triangle_overlap_2d: 2D triangle pair overlap by separating edges (top level).
// Registered path: input register, then result register.
// Throughput: one pair per cycle unless out_stall stalls; one multiplier layer in between.
// Reset (rst_n low, synchronous) empties both stages and loads edge_epsilon = 0,
// allow_reversed = 1, touch_collides = 1. Uses tov_pkg, tov_det, tov_sep and the defines.
`include "triangle_overlap_2d_defines.svh"

module triangle_overlap_2d #(
  parameter int COORD_BITS = tov_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [tov_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tov_pkg::EPS_BITS-1:0]      cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_BITS-1:0]      in_a_x0,
  input  logic signed [COORD_BITS-1:0]      in_a_y0,
  input  logic signed [COORD_BITS-1:0]      in_a_x1,
  input  logic signed [COORD_BITS-1:0]      in_a_y1,
  input  logic signed [COORD_BITS-1:0]      in_a_x2,
  input  logic signed [COORD_BITS-1:0]      in_a_y2,
  input  logic signed [COORD_BITS-1:0]      in_b_x0,
  input  logic signed [COORD_BITS-1:0]      in_b_y0,
  input  logic signed [COORD_BITS-1:0]      in_b_x1,
  input  logic signed [COORD_BITS-1:0]      in_b_y1,
  input  logic signed [COORD_BITS-1:0]      in_b_x2,
  input  logic signed [COORD_BITS-1:0]      in_b_y2,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_overlap,
  output logic                              out_winding_error
);
  import tov_pkg::*;

  localparam int DW = 2 * COORD_BITS + 3;

  tov_cfg_t cfg_r;

  logic                         s1_valid_r, s1_valid_nxt;
  logic signed [COORD_BITS-1:0] ax_r [3];
  logic signed [COORD_BITS-1:0] ay_r [3];
  logic signed [COORD_BITS-1:0] bx_r [3];
  logic signed [COORD_BITS-1:0] by_r [3];

  logic out_valid_r, out_valid_nxt;
  logic out_overlap_r, out_overlap_nxt;
  logic out_winding_error_r, out_winding_error_nxt;

  logic s1_load, out_free;

  logic signed [DW-1:0] area_a, area_b;
  logic signed [DW-1:0] det_a [3][3];
  logic signed [DW-1:0] det_b [3][3];
  logic neg_a, neg_b, sep_a, sep_b, wind_err;

  // Configuration registers: take a write when enabled, drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.edge_epsilon   <= EDGE_EPSILON_RST;
      cfg_r.allow_reversed <= ALLOW_REVERSED_RST;
      cfg_r.touch_collides <= TOUCH_COLLIDES_RST;
    end else if (cfg_we) begin
      case (tov_reg_t'(cfg_index))
        REG_EDGE_EPSILON:   cfg_r.edge_epsilon   <= cfg_data;
        REG_ALLOW_REVERSED: cfg_r.allow_reversed <= cfg_data[0];
        REG_TOUCH_COLLIDES: cfg_r.touch_collides <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees when empty or being taken
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign s1_load  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = s1_load ? 1'b1 : (out_free ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register: capture coordinates on an accepted beat
  always_ff @(posedge clk) begin
    if (s1_load) begin
      ax_r[0] <= in_a_x0;  ay_r[0] <= in_a_y0;
      ax_r[1] <= in_a_x1;  ay_r[1] <= in_a_y1;
      ax_r[2] <= in_a_x2;  ay_r[2] <= in_a_y2;
      bx_r[0] <= in_b_x0;  by_r[0] <= in_b_y0;
      bx_r[1] <= in_b_x1;  by_r[1] <= in_b_y1;
      bx_r[2] <= in_b_x2;  by_r[2] <= in_b_y2;
    end
  end

  // Signed area of each triangle decides its winding
  tov_det #(.COORD_BITS(COORD_BITS)) u_area_a (
    .px(ax_r[0]), .py(ay_r[0]), .qx(ax_r[1]), .qy(ay_r[1]),
    .rx(ax_r[2]), .ry(ay_r[2]), .det(area_a)
  );
  tov_det #(.COORD_BITS(COORD_BITS)) u_area_b (
    .px(bx_r[0]), .py(by_r[0]), .qx(bx_r[1]), .qy(by_r[1]),
    .rx(bx_r[2]), .ry(by_r[2]), .det(area_b)
  );

  // Edge determinants in original vertex order; reversal is applied as a sign flip
  for (genvar gi = 0; gi < 3; gi++) begin : g_edge
    for (genvar gk = 0; gk < 3; gk++) begin : g_vtx
      tov_det #(.COORD_BITS(COORD_BITS)) u_det_a (
        .px(ax_r[gi]), .py(ay_r[gi]),
        .qx(ax_r[(gi + 1) % 3]), .qy(ay_r[(gi + 1) % 3]),
        .rx(bx_r[gk]), .ry(by_r[gk]), .det(det_a[gi][gk])
      );
      tov_det #(.COORD_BITS(COORD_BITS)) u_det_b (
        .px(bx_r[gi]), .py(by_r[gi]),
        .qx(bx_r[(gi + 1) % 3]), .qy(by_r[(gi + 1) % 3]),
        .rx(ax_r[gk]), .ry(ay_r[gk]), .det(det_b[gi][gk])
      );
    end
  end

  assign neg_a = area_a[DW-1];
  assign neg_b = area_b[DW-1];

  tov_sep #(.COORD_BITS(COORD_BITS)) u_sep_a (
    .det_i(det_a), .flip(neg_a), .cfg(cfg_r), .sep(sep_a)
  );
  tov_sep #(.COORD_BITS(COORD_BITS)) u_sep_b (
    .det_i(det_b), .flip(neg_b), .cfg(cfg_r), .sep(sep_b)
  );

  // Combine: a clockwise triangle with reversal off is an error and never overlaps
  always_comb begin
    wind_err              = (neg_a || neg_b) && !cfg_r.allow_reversed;
    out_winding_error_nxt = wind_err;
    out_overlap_nxt       = !wind_err && !sep_a && !sep_b;
  end

  // Result register: load when free and a pair is waiting
  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_overlap_r       <= out_overlap_nxt;
      out_winding_error_r <= out_winding_error_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_overlap       = out_overlap_r;
  assign out_winding_error = out_winding_error_r;

  // Checks
  `TOV_ASSERT_NOW(a_excl_result, out_valid_r, !(out_overlap_r && out_winding_error_r), "overlap and winding error both set")
  `TOV_ASSERT_NOW(a_err_needs_cfg, out_valid_r && out_winding_error_r, !cfg_r.allow_reversed, "winding error while reversal allowed")
  `TOV_ASSERT_NEXT(a_stage_advance, s1_valid_r && out_free, out_valid_r, "pair lost between stages")
  `TOV_ASSERT_NOW(a_stall_full, in_stall, s1_valid_r && out_valid_r, "input stalled with room in the pipe")

endmodule

FILE: verif/tb_triangle_overlap_2d.sv
// Testbench for triangle_overlap_2d: directed pairs, then random pairs under several settings.
// Checks each result beat against a planned verdict or a local overlap predictor; the stall pattern is its own.
// Depends on tov_pkg and the triangle_overlap_2d RTL only.
module tb_triangle_overlap_2d;
  import tov_pkg::*;

  localparam int CB        = COORD_BITS_DEF;
  localparam int PHASES    = 8;
  localparam int PER_PHASE = 241;
  localparam int LIMIT     = 400000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    coord_t x0, y0, x1, y1, x2, y2;
  } tri_t;
  typedef struct packed {
    tri_t a, b;
  } pair_t;
  typedef struct packed {
    logic overlap;
    logic winding_error;
  } verdict_t;
  typedef struct {
    pair_t               pair;
    logic [EPS_BITS-1:0] eps_raw, rev_raw, touch_raw;
    bit                  typed;
    verdict_t            want;
  } row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [EPS_BITS-1:0]     cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  coord_t in_a_x0 = '0, in_a_y0 = '0, in_a_x1 = '0, in_a_y1 = '0, in_a_x2 = '0, in_a_y2 = '0;
  coord_t in_b_x0 = '0, in_b_y0 = '0, in_b_x1 = '0, in_b_y1 = '0, in_b_x2 = '0, in_b_y2 = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_overlap;
  logic                    out_winding_error;

  // Local copy of the configuration registers
  longint              eps_q = 0;
  bit                  rev_ok = 1'b1;
  bit                  touch_strict = 1'b1;
  logic [EPS_BITS-1:0] cur_eps = '0, cur_rev = 32'd1, cur_touch = 32'd1;

  verdict_t pending_verdicts [$];
  int       mismatches = 0;
  int       cycles = 0;
  int       burst_left = 0;
  int       stall_mode = 0;
  int       stall_left = 0;
  logic [31:0] tick = '0;

  triangle_overlap_2d dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_a_x0           (in_a_x0),
    .in_a_y0           (in_a_y0),
    .in_a_x1           (in_a_x1),
    .in_a_y1           (in_a_y1),
    .in_a_x2           (in_a_x2),
    .in_a_y2           (in_a_y2),
    .in_b_x0           (in_b_x0),
    .in_b_y0           (in_b_y0),
    .in_b_x1           (in_b_x1),
    .in_b_y1           (in_b_y1),
    .in_b_x2           (in_b_x2),
    .in_b_y2           (in_b_y2),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_overlap       (out_overlap),
    .out_winding_error (out_winding_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Twice the signed area of p, q, r (exact, Q16.16 for Q8.8 points)
  function automatic longint twice_area(longint px, longint py, longint qx, longint qy,
                                        longint rx, longint ry);
    return px * (qy - ry) + qx * (ry - py) + rx * (py - qy);
  endfunction

  function automatic bit beyond(longint d);
    return touch_strict ? (d < eps_q) : (d <= eps_q);
  endfunction

  // True if some edge of e leaves every vertex of o on its outer side
  function automatic bit edge_separates(tri_t e, tri_t o);
    longint ex [3];
    longint ey [3];
    longint ox [3];
    longint oy [3];
    int     j;
    bit     all_out;
    ex = '{e.x0, e.x1, e.x2};
    ey = '{e.y0, e.y1, e.y2};
    ox = '{o.x0, o.x1, o.x2};
    oy = '{o.y0, o.y1, o.y2};
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      all_out = 1'b1;
      for (int k = 0; k < 3; k++)
        if (!beyond(twice_area(ex[i], ey[i], ex[j], ey[j], ox[k], oy[k]))) all_out = 1'b0;
      if (all_out) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t overlap_verdict(pair_t p);
    tri_t     a, b;
    bit       cw_a, cw_b;
    verdict_t v;
    a = p.a;
    b = p.b;
    cw_a = twice_area(a.x0, a.y0, a.x1, a.y1, a.x2, a.y2) < 0;
    cw_b = twice_area(b.x0, b.y0, b.x1, b.y1, b.x2, b.y2) < 0;
    if ((cw_a || cw_b) && !rev_ok) begin
      v.overlap = 1'b0;
      v.winding_error = 1'b1;
      return v;
    end
    // Swap the last two vertices of a clockwise triangle
    if (cw_a) a = '{a.x0, a.y0, a.x2, a.y2, a.x1, a.y1};
    if (cw_b) b = '{b.x0, b.y0, b.x2, b.y2, b.x1, b.y1};
    v.overlap = !(edge_separates(a, b) || edge_separates(b, a));
    v.winding_error = 1'b0;
    return v;
  endfunction

  function automatic tri_t corners(int x0, int y0, int x1, int y1, int x2, int y2);
    return '{coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1), coord_t'(x2), coord_t'(y2)};
  endfunction

  function automatic row_t plan_row(tri_t a, tri_t b, logic [EPS_BITS-1:0] e,
                                    logic [EPS_BITS-1:0] r, logic [EPS_BITS-1:0] t,
                                    bit typed, logic ov, logic werr);
    row_t row;
    row.pair = '{a, b};
    row.eps_raw = e;
    row.rev_raw = r;
    row.touch_raw = t;
    row.typed = typed;
    row.want = '{ov, werr};
    return row;
  endfunction

  // Mix of full-range, clustered (touching, collinear) and mid-range pairs
  function automatic pair_t random_pair();
    pair_t p;
    int    mode;
    int    step;
    int    base [2];
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      p = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    end else if (mode < 8) begin
      base[0] = int'($urandom_range(0, 64000)) - 32000;
      base[1] = int'($urandom_range(0, 64000)) - 32000;
      case ($urandom_range(0, 2))
        0: step = 1;
        1: step = 16;
        default: step = 256;
      endcase
      for (int k = 0; k < 12; k++)
        p[k*CB +: CB] = coord_t'(base[k % 2] + step * (int'($urandom_range(0, 6)) - 3));
    end else begin
      for (int k = 0; k < 12; k++)
        p[k*CB +: CB] = coord_t'(int'($urandom_range(0, 4095)) - 2048);
    end
    return p;
  endfunction

  // Drop valid and hold until every expected verdict has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_cfg(logic [EPS_BITS-1:0] e, logic [EPS_BITS-1:0] r,
                          logic [EPS_BITS-1:0] t);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_EDGE_EPSILON;
    cfg_data <= e;
    @(negedge clk);
    cfg_index <= REG_ALLOW_REVERSED;
    cfg_data <= r;
    @(negedge clk);
    cfg_index <= REG_TOUCH_COLLIDES;
    cfg_data <= t;
    @(negedge clk);
    cfg_we <= 1'b0;
    // Only bit 0 of the reversal and touch registers survives; the tolerance keeps all its bits
    eps_q = longint'($signed(e));
    rev_ok = r[0];
    touch_strict = t[0];
    cur_eps = e;
    cur_rev = r;
    cur_touch = t;
  endtask

  // Insert a random gap at the start of each burst
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: gap = $urandom_range(0, 3);
        7, 8: gap = $urandom_range(4, 12);
        default: gap = 0;
      endcase
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // Present one beat and hold it until accepted
  task automatic drive(pair_t p, verdict_t v);
    @(negedge clk);
    in_valid <= 1'b1;
    in_a_x0 <= p.a.x0;
    in_a_y0 <= p.a.y0;
    in_a_x1 <= p.a.x1;
    in_a_y1 <= p.a.y1;
    in_a_x2 <= p.a.x2;
    in_a_y2 <= p.a.y2;
    in_b_x0 <= p.b.x0;
    in_b_y0 <= p.b.y0;
    in_b_x1 <= p.b.x1;
    in_b_y1 <= p.b.y1;
    in_b_x2 <= p.b.x2;
    in_b_y2 <= p.b.y2;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(v);
  endtask

  // Receiver stall pattern: pick a new random mode whenever the current one runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    tick = tick + 1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      3: out_stall <= tick[0];
      default: out_stall <= (tick[2:0] < 3'd5);
    endcase
  end

  // Compare each result beat with the oldest expected verdict
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no expected verdict");
        mismatches++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (out_overlap !== exp_v.overlap) begin
          $error("overlap: expected %0b, got %0b", exp_v.overlap, out_overlap);
          mismatches++;
        end
        if (out_winding_error !== exp_v.winding_error) begin
          $error("winding_error: expected %0b, got %0b", exp_v.winding_error,
                 out_winding_error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    tri_t     zero_t, max_t, min_t, unit, unit_cw, far_t, vtx_touch, edge_touch;
    tri_t     inner, inner_cw, line3, ext_ccw, ext_cw, ext_opp;
    row_t     plan [25];
    verdict_t want;
    pair_t    p;
    logic [EPS_BITS-1:0] e, r, t;

    zero_t     = corners(0, 0, 0, 0, 0, 0);
    max_t      = corners(32767, 32767, 32767, 32767, 32767, 32767);
    min_t      = corners(-32768, -32768, -32768, -32768, -32768, -32768);
    unit       = corners(0, 0, 256, 0, 0, 256);
    unit_cw    = corners(0, 0, 0, 256, 256, 0);
    far_t      = corners(2560, 2560, 2816, 2560, 2560, 2816);
    vtx_touch  = corners(256, 0, 512, 0, 256, 256);
    edge_touch = corners(256, 0, 256, 256, 0, 256);
    inner      = corners(64, 64, 128, 64, 64, 128);
    inner_cw   = corners(64, 64, 64, 128, 128, 64);
    line3      = corners(0, 0, 256, 256, 512, 512);
    ext_ccw    = corners(-32768, -32768, 32767, -32768, -32768, 32767);
    ext_cw     = corners(32767, -32768, -32768, -32768, -32768, 32767);
    ext_opp    = corners(32767, 32767, -32768, 32767, 32767, -32768);

    // Reset settings: degenerate points, extremes, orientation, contact
    plan[0]  = plan_row(zero_t, zero_t, 32'd0, 32'd1, 32'd1, 1'b1, 1'b1, 1'b0);
    plan[1]  = plan_row(max_t, max_t, 32'd0, 32'd1, 32'd1, 1'b1, 1'b1, 1'b0);
    plan[2]  = plan_row(min_t, min_t, 32'd0, 32'd1, 32'd1, 1'b1, 1'b1, 1'b0);
    plan[3]  = plan_row(unit, unit, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0, 1'b0);
    plan[4]  = plan_row(unit, far_t, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0, 1'b0);
    plan[5]  = plan_row(unit, vtx_touch, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0, 1'b0);
    plan[6]  = plan_row(unit, edge_touch, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0, 1'b0);
    plan[7]  = plan_row(unit_cw, inner, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0, 1'b0);
    plan[8]  = plan_row(unit, inner_cw, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0, 1'b0);
    plan[9]  = plan_row(line3, unit, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0, 1'b0);
    plan[10] = plan_row(ext_ccw, ext_opp, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0, 1'b0);
    plan[11] = plan_row(ext_cw, inner, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0, 1'b0);
    // Boundary contact does not collide
    plan[12] = plan_row(unit, vtx_touch, 32'd0, 32'd1, 32'd0, 1'b0, 1'b0, 1'b0);
    plan[13] = plan_row(unit, edge_touch, 32'd0, 32'd1, 32'd0, 1'b0, 1'b0, 1'b0);
    plan[14] = plan_row(zero_t, zero_t, 32'd0, 32'd1, 32'd0, 1'b0, 1'b0, 1'b0);
    plan[15] = plan_row(line3, unit, 32'd0, 32'd1, 32'd0, 1'b0, 1'b0, 1'b0);
    // Reversal off: clockwise triangles flag a winding error
    plan[16] = plan_row(unit_cw, inner, 32'd0, 32'd0, 32'd1, 1'b1, 1'b0, 1'b1);
    plan[17] = plan_row(unit, inner_cw, 32'd0, 32'd0, 32'd1, 1'b1, 1'b0, 1'b1);
    plan[18] = plan_row(ext_cw, unit_cw, 32'd0, 32'd0, 32'd1, 1'b1, 1'b0, 1'b1);
    plan[19] = plan_row(unit, inner, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0, 1'b0);
    plan[20] = plan_row(line3, inner, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0, 1'b0);
    // Tolerance extremes, upper register bits set
    plan[21] = plan_row(unit, far_t, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                        1'b0, 1'b0, 1'b0);
    plan[22] = plan_row(ext_ccw, ext_opp, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                        1'b0, 1'b0, 1'b0);
    plan[23] = plan_row(unit, unit, 32'h8000_0000, 32'd2, 32'd3, 1'b0, 1'b0, 1'b0);
    plan[24] = plan_row(ext_cw, inner, 32'h8000_0000, 32'd2, 32'd3, 1'b1, 1'b0, 1'b1);

    // Hold reset, then release it at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].eps_raw !== cur_eps || plan[i].rev_raw !== cur_rev ||
          plan[i].touch_raw !== cur_touch) begin
        settle();
        load_cfg(plan[i].eps_raw, plan[i].rev_raw, plan[i].touch_raw);
      end
      want = plan[i].typed ? plan[i].want : overlap_verdict(plan[i].pair);
      pace();
      drive(plan[i].pair, want);
    end

    // Random pairs, one setting per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: e = '0;
        1: e = $urandom_range(0, 1 << 20);
        2: e = -$urandom_range(0, 1 << 20);
        default: e = $urandom();
      endcase
      r = $urandom();
      t = $urandom();
      case (ph)
        0: e = 32'h7FFF_FFFF;
        1: e = 32'h8000_0000;
        2: begin
          e = '0;
          t = 32'd0;
        end
        3: r = 32'd0;
        default: ;
      endcase
      settle();
      load_cfg(e, r, t);
      for (int k = 0; k < PER_PHASE; k++) begin
        // Pause mid-phase until the pipeline is empty
        if (ph == 4 && k == PER_PHASE / 2) settle();
        p = random_pair();
        pace();
        drive(p, overlap_verdict(p));
      end
    end

    settle();
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
